// File: hdl/cau_pkg.sv
// shared types, opcodes and saturation helpers for the complex arithmetic unit
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         saturated;
    logic                         divide_by_zero;
  } rsp_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  sat;
  } clip_t;

  // result of everything but a real division, plus the division signs
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  re_neg;
    logic                  im_neg;
    logic [DATA_WIDTH-1:0] res_re;
    logic [DATA_WIDTH-1:0] res_im;
    logic                  sat;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic [PROD_WIDTH-1:0] den;
    logic [PROD_WIDTH-1:0] num_re;
    logic [PROD_WIDTH-1:0] num_im;
    logic [PROD_WIDTH-1:0] rem_re;
    logic [PROD_WIDTH-1:0] rem_im;
  } divw_t;

  // hi marks a magnitude far beyond range, lo holds the low bits
  function automatic clip_t sat_clip(input logic neg, input logic hi,
                                     input logic [DATA_WIDTH:0] lo);
    clip_t                 r;
    logic [DATA_WIDTH:0]   pos_max;
    logic [DATA_WIDTH:0]   neg_mag;
    pos_max = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    neg_mag = {2'b01, {(DATA_WIDTH-1){1'b0}}};
    if (!neg) begin
      r.sat = hi || (lo > pos_max);
      r.val = r.sat ? pos_max[DATA_WIDTH-1:0] : lo[DATA_WIDTH-1:0];
    end else begin
      r.sat = hi || (lo > neg_mag);
      r.val = r.sat ? neg_mag[DATA_WIDTH-1:0] : (~lo[DATA_WIDTH-1:0] + 1'b1);
    end
    return r;
  endfunction

  function automatic clip_t clip_sum(input logic signed [DATA_WIDTH:0] s);
    logic                neg;
    logic [DATA_WIDTH:0] mag;
    neg = s[DATA_WIDTH];
    mag = neg ? (~s + 1'b1) : s;
    return sat_clip(neg, 1'b0, mag);
  endfunction

endpackage

// File: hdl/cau_front.sv
// operand stages: products, sums, simple ops and divider load
module cau_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cau_pkg::req_t     req,
  output logic              out_valid,
  input  logic              out_ready,
  output cau_pkg::divw_t    out_div
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_WIDTH;
  localparam int IW = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 2;

  function automatic cau_pkg::clip_t inc_clip(input logic signed [DW-1:0] x);
    logic signed [IW-1:0] s;
    logic [IW-1:0]        mag;
    logic                 neg;
    s   = IW'(x) + (IW'(1) << FRAC_BITS);
    neg = s[IW-1];
    mag = neg ? (~s + 1'b1) : s;
    return cau_pkg::sat_clip(neg, |mag[IW-1:DW+1], mag[DW:0]);
  endfunction

  // stage a
  logic                 a_v;
  logic                 a_rdy;
  logic [2:0]           a_op;
  logic signed [PW-1:0] pac, pbd, pad, pbc, pcc, pdd;
  logic [DW-1:0]        a_sre, a_sim;
  logic                 a_ssat;
  cau_pkg::clip_t       cre, cim;

  // stage b
  logic                 b_v;
  logic                 b_rdy;
  logic [2:0]           b_op;
  logic [DW-1:0]        b_sre, b_sim;
  logic                 b_ssat;
  logic signed [PW:0]   mre, mim, nre, nim;
  logic [PW-1:0]        den;

  // stage c
  logic                 c_v;
  logic                 c_rdy;
  cau_pkg::divw_t       div_next;
  logic [PW:0]          mag_mre, mag_mim, sh_re, sh_im, mag_nre, mag_nim;
  cau_pkg::clip_t       mc_re, mc_im;

  assign a_rdy     = !a_v || b_rdy;
  assign b_rdy     = !b_v || c_rdy;
  assign c_rdy     = !c_v || out_ready;
  assign req_ready = a_rdy;
  assign out_valid = c_v;

  always_comb begin
    cre = '0;
    cim = '0;
    unique case (req.req_type)
      cau_pkg::OP_ADD: begin
        cre = cau_pkg::clip_sum((DW+1)'(req.a_re) + (DW+1)'(req.b_re));
        cim = cau_pkg::clip_sum((DW+1)'(req.a_im) + (DW+1)'(req.b_im));
      end
      cau_pkg::OP_SUB: begin
        cre = cau_pkg::clip_sum((DW+1)'(req.a_re) - (DW+1)'(req.b_re));
        cim = cau_pkg::clip_sum((DW+1)'(req.a_im) - (DW+1)'(req.b_im));
      end
      cau_pkg::OP_NEG: begin
        cre = cau_pkg::clip_sum(-(DW+1)'(req.a_re));
        cim = cau_pkg::clip_sum(-(DW+1)'(req.a_im));
      end
      cau_pkg::OP_INC: begin
        cre = inc_clip(req.a_re);
        cim = inc_clip(req.a_im);
      end
      default: begin
        cre = '0;
        cim = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && req_valid) begin
      a_op   <= req.req_type;
      pac    <= req.a_re * req.b_re;
      pbd    <= req.a_im * req.b_im;
      pad    <= req.a_re * req.b_im;
      pbc    <= req.a_im * req.b_re;
      pcc    <= req.b_re * req.b_re;
      pdd    <= req.b_im * req.b_im;
      a_sre  <= cre.val;
      a_sim  <= cim.val;
      a_ssat <= cre.sat | cim.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_rdy) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v) begin
      b_op   <= a_op;
      b_sre  <= a_sre;
      b_sim  <= a_sim;
      b_ssat <= a_ssat;
      mre    <= (PW+1)'(pac) - (PW+1)'(pbd);
      mim    <= (PW+1)'(pad) + (PW+1)'(pbc);
      nre    <= (PW+1)'(pac) + (PW+1)'(pbd);
      nim    <= (PW+1)'(pbc) - (PW+1)'(pad);
      den    <= pcc[PW-1:0] + pdd[PW-1:0];
    end
  end

  always_comb begin
    mag_mre = mre[PW] ? (~mre + 1'b1) : mre;
    mag_mim = mim[PW] ? (~mim + 1'b1) : mim;
    mag_nre = nre[PW] ? (~nre + 1'b1) : nre;
    mag_nim = nim[PW] ? (~nim + 1'b1) : nim;
    // multiply truncates the magnitude, i.e. toward zero
    sh_re   = mag_mre >> FRAC_BITS;
    sh_im   = mag_mim >> FRAC_BITS;
    mc_re   = cau_pkg::sat_clip(mre[PW], |sh_re[PW:DW+1], sh_re[DW:0]);
    mc_im   = cau_pkg::sat_clip(mim[PW], |sh_im[PW:DW+1], sh_im[DW:0]);

    div_next             = '0;
    div_next.den         = den;
    div_next.num_re      = mag_nre[PW-1:0];
    div_next.num_im      = mag_nim[PW-1:0];
    div_next.side.re_neg = nre[PW];
    div_next.side.im_neg = nim[PW];
    unique case (b_op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG, cau_pkg::OP_INC: begin
        div_next.side.res_re = b_sre;
        div_next.side.res_im = b_sim;
        div_next.side.sat    = b_ssat;
      end
      cau_pkg::OP_MUL: begin
        div_next.side.res_re = mc_re.val;
        div_next.side.res_im = mc_im.val;
        div_next.side.sat    = mc_re.sat | mc_im.sat;
      end
      cau_pkg::OP_DIV: begin
        div_next.side.is_div = 1'b1;
        div_next.side.dz     = (den == '0);
      end
      default: begin
        div_next.side.is_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_rdy) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_v) begin
      out_div <= div_next;
    end
  end

endmodule

// File: hdl/cau_div_cell.sv
// one restoring-division cell: one quotient bit for both parts
module cau_div_cell #(
  parameter int QW = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cau_pkg::divw_t    in_div,
  input  logic [QW-1:0]     in_q_re,
  input  logic [QW-1:0]     in_q_im,
  output logic              out_valid,
  input  logic              out_ready,
  output cau_pkg::divw_t    out_div,
  output logic [QW-1:0]     out_q_re,
  output logic [QW-1:0]     out_q_im
);

  localparam int PW = cau_pkg::PROD_WIDTH;

  logic            v;
  logic [PW:0]     r2_re, r2_im, dext, rn_re, rn_im;
  logic            ge_re, ge_im;
  cau_pkg::divw_t  div_next;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin
    dext     = {1'b0, in_div.den};
    r2_re    = {in_div.rem_re, in_div.num_re[PW-1]};
    r2_im    = {in_div.rem_im, in_div.num_im[PW-1]};
    ge_re    = r2_re >= dext;
    ge_im    = r2_im >= dext;
    rn_re    = ge_re ? (r2_re - dext) : r2_re;
    rn_im    = ge_im ? (r2_im - dext) : r2_im;
    div_next        = in_div;
    div_next.rem_re = rn_re[PW-1:0];
    div_next.rem_im = rn_im[PW-1:0];
    // fraction bits come from the zeros shifted in behind the numerator
    div_next.num_re = {in_div.num_re[PW-2:0], 1'b0};
    div_next.num_im = {in_div.num_im[PW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_div  <= div_next;
      out_q_re <= {in_q_re[QW-2:0], ge_re};
      out_q_im <= {in_q_im[QW-2:0], ge_im};
    end
  end

endmodule

// File: hdl/cau_out.sv
// quotient saturation and output register
module cau_out #(
  parameter int QW = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cau_pkg::divw_t    in_div,
  input  logic [QW-1:0]     in_q_re,
  input  logic [QW-1:0]     in_q_im,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cau_pkg::rsp_t     rsp
);

  localparam int DW = cau_pkg::DATA_WIDTH;

  logic            v;
  cau_pkg::clip_t  qc_re, qc_im;
  cau_pkg::rsp_t   rsp_next;

  assign in_ready  = !v || rsp_ready;
  assign rsp_valid = v;

  always_comb begin
    qc_re = cau_pkg::sat_clip(in_div.side.re_neg, |in_q_re[QW-1:DW+1], in_q_re[DW:0]);
    qc_im = cau_pkg::sat_clip(in_div.side.im_neg, |in_q_im[QW-1:DW+1], in_q_im[DW:0]);
    rsp_next.divide_by_zero = in_div.side.dz;
    if (in_div.side.is_div && !in_div.side.dz) begin
      rsp_next.res_re    = qc_re.val;
      rsp_next.res_im    = qc_im.val;
      rsp_next.saturated = qc_re.sat | qc_im.sat;
    end else begin
      rsp_next.res_re    = in_div.side.res_re;
      rsp_next.res_im    = in_div.side.res_im;
      rsp_next.saturated = in_div.side.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hdl/complex_arith_unit_top.sv
// complex arithmetic unit: signed fixed-point add, sub, mul, div, negate, increment
//
// requests enter on req (opcode and operands a, b) with req_valid/req_ready;
// each gives exactly one response on rsp with rsp_valid/rsp_ready, in order.
// every request takes the same path: three operand stages (products, sums,
// divider load), a row of 2*DATA_WIDTH+FRAC_BITS division cells that each
// retire one quotient bit of both parts, and an output register; the default
// format is Q8.8. one request is taken per cycle unless back-pressure from
// a stalled receiver holds the pipeline.
// every stage has its own valid bit and moves when the stage after it is
// empty or moving, so while a response is held by a stalled receiver the
// bubbles upstream still fill and requests keep being taken until the row is
// full. reset empties all stages; no response is pending afterwards.
// overflowing parts saturate and set saturated; a divide by zero returns zero
// with divide_by_zero set.
module complex_arith_unit_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cau_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cau_pkg::rsp_t  rsp
);

  localparam int PW    = cau_pkg::PROD_WIDTH;
  localparam int NSTEP = PW + FRAC_BITS;
  localparam int QW    = PW + FRAC_BITS;

  logic           cv   [0:NSTEP];
  logic           crdy [0:NSTEP];
  cau_pkg::divw_t cdiv [0:NSTEP];
  logic [QW-1:0]  cqre [0:NSTEP];
  logic [QW-1:0]  cqim [0:NSTEP];

  cau_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (cv[0]),
    .out_ready (crdy[0]),
    .out_div   (cdiv[0])
  );

  assign cqre[0] = '0;
  assign cqim[0] = '0;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    cau_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (crdy[i]),
      .in_div    (cdiv[i]),
      .in_q_re   (cqre[i]),
      .in_q_im   (cqim[i]),
      .out_valid (cv[i+1]),
      .out_ready (crdy[i+1]),
      .out_div   (cdiv[i+1]),
      .out_q_re  (cqre[i+1]),
      .out_q_im  (cqim[i+1])
    );
  end

  cau_out #(
    .QW (QW)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[NSTEP]),
    .in_ready  (crdy[NSTEP]),
    .in_div    (cdiv[NSTEP]),
    .in_q_re   (cqre[NSTEP]),
    .in_q_im   (cqim[NSTEP]),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |->
      rsp.res_re == '0 && rsp.res_im == '0 && !rsp.saturated)
    else $error("divide by zero response not cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cv[0])
    else $error("pipeline not empty after reset");

  a_row_flow: assert property (@(posedge clk) disable iff (rst)
    cv[NSTEP] && crdy[NSTEP] |=> rsp_valid)
    else $error("division row result lost at output");

endmodule

// File: tb/cau_checker.sv
// response checker for the complex arithmetic unit: predicts each response and compares
`timescale 1ns / 1ps
module cau_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  cau_pkg::req_t  req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  cau_pkg::rsp_t  rsp,
  output int             fail_count,
  output int             pending
);

  localparam int FRAC = 8;
  localparam logic signed [63:0] POS_MAX = 64'sd32767;
  localparam logic signed [63:0] NEG_MIN = -64'sd32768;

  cau_pkg::rsp_t expected_rsp[$];

  // clip a wide signed value to the 16-bit range
  function automatic logic [15:0] clamp16(input logic signed [63:0] v, inout logic sat);
    if (v > POS_MAX) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < NEG_MIN) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // truncate toward zero: divide magnitudes, then restore the sign
  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
    logic [63:0] mag;
    mag = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    if (mag > 64'd1099511627776) mag = 64'd1099511627776;
    return ((n < 0) != (d < 0)) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cau_pkg::rsp_t compute_complex(input cau_pkg::req_t r);
    cau_pkg::rsp_t o;
    logic signed [63:0] ar, ai, br, bi, pr, pi, den;
    logic sat;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    sat = 1'b0;
    o = '0;
    case (r.req_type)
      cau_pkg::OP_ADD: begin
        o.res_re = clamp16(ar + br, sat);
        o.res_im = clamp16(ai + bi, sat);
      end
      cau_pkg::OP_SUB: begin
        o.res_re = clamp16(ar - br, sat);
        o.res_im = clamp16(ai - bi, sat);
      end
      cau_pkg::OP_MUL: begin
        pr = div_trunc(ar * br - ai * bi, 64'sd1 << FRAC);
        pi = div_trunc(ar * bi + ai * br, 64'sd1 << FRAC);
        o.res_re = clamp16(pr, sat);
        o.res_im = clamp16(pi, sat);
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          pr = div_trunc((ar * br + ai * bi) * (64'sd1 << FRAC), den);
          pi = div_trunc((ai * br - ar * bi) * (64'sd1 << FRAC), den);
          o.res_re = clamp16(pr, sat);
          o.res_im = clamp16(pi, sat);
        end
      end
      cau_pkg::OP_NEG: begin
        o.res_re = clamp16(-ar, sat);
        o.res_im = clamp16(-ai, sat);
      end
      cau_pkg::OP_INC: begin
        o.res_re = clamp16(ar + (64'sd1 << FRAC), sat);
        o.res_im = clamp16(ai + (64'sd1 << FRAC), sat);
      end
      default: ;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input cau_pkg::rsp_t got,
                                 input cau_pkg::rsp_t want);
    $display({"cau_checker: %s mismatch got re=%h im=%h sat=%b dz=%b",
              " want re=%h im=%h sat=%b dz=%b"},
             what, got.res_re, got.res_im, got.saturated, got.divide_by_zero,
             want.res_re, want.res_im, want.saturated, want.divide_by_zero);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cau_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsp.push_back(compute_complex(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.res_re !== want.res_re) report_mismatch("res_re", rsp, want);
          if (rsp.res_im !== want.res_im) report_mismatch("res_im", rsp, want);
          if (rsp.saturated !== want.saturated) report_mismatch("saturated", rsp, want);
          if (rsp.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", rsp, want);
        end
      end
    end
    pending = expected_rsp.size();
  end
endmodule

// File: tb/tb_top.sv
// stimulus and verdict for the complex arithmetic unit
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY = 44;
  localparam int RANDOM_REQS = 550;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  cau_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cau_pkg::rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   idle_enable = 1'b1;
  bit   hold_rsp = 1'b0;
  bit   stim_done = 1'b0;

  always #1 clk = ~clk;

  complex_arith_unit_top dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  cau_checker checker_i (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0100;
      4: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one request, after an optional random idle gap, and hold it until taken
  task automatic send_request(input logic [2:0] op, input logic [15:0] ar, input logic [15:0] ai,
                              input logic [15:0] br, input logic [15:0] bi);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{req_type: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // response side: random stall bursts plus one long hold-off
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: every operation and the corner operands
    send_request(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_request(cau_pkg::OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    send_request(cau_pkg::OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
    send_request(cau_pkg::OP_MUL, 16'h0180, 16'hfe80, 16'h0200, 16'h0100);
    send_request(cau_pkg::OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_request(cau_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
    send_request(cau_pkg::OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
    send_request(cau_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
    send_request(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_request(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff);
    send_request(cau_pkg::OP_NEG, 16'h8000, 16'h7fff, 16'h1234, 16'h5678);
    send_request(cau_pkg::OP_NEG, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_request(cau_pkg::OP_INC, 16'h7fff, 16'h7f00, 16'h0000, 16'h0000);
    send_request(cau_pkg::OP_INC, 16'h8000, 16'hff00, 16'hffff, 16'hffff);
    send_request(3'd6, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
    send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // random with a long receiver hold-off early on
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 40) hold_rsp = 1'b1;
      if (i == RANDOM_REQS - 80) idle_enable = 1'b0;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (op == cau_pkg::OP_DIV && $urandom_range(0, 7) == 0)
        send_request(op, pick_operand(), pick_operand(), 16'h0000, 16'h0000);
      else
        send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_div_cell.sv
hdl/cau_out.sv
hdl/complex_arith_unit_top.sv
tb/cau_checker.sv
tb/tb_top.sv
